// ===== sv/wbec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed bad event counter package
// Shared widths, constants and the control and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package wbec_pkg;

    localparam int DAY_W           = 16;
    localparam int SEC_W           = 17;
    localparam int WIN_W           = 17;
    localparam int OUT_W           = 7;
    localparam int AGE_W           = 36;
    localparam int SECONDS_PER_DAY = 86400;
    localparam int SLOTS_DEFAULT   = 64;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3600);

    typedef struct packed {
        logic load;
        logic write;
        logic start;
        logic walk;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic walk_done;
    } t_status;

endpackage

// ===== sv/wbec_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed bad event counter controller
// Sequences one item through capture, ring write, backward walk and result
// hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module wbec_ctrl
    import wbec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_START,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
        o_cmd.write   = (r_state == S_WRITE);
        o_cmd.start   = (r_state == S_START);
        o_cmd.walk    = (r_state == S_WALK);
        o_cmd.publish = (r_state == S_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_in_stall <= 1'b1;
                        r_state    <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= i_status.empty ? S_DONE : S_WALK;
                end
                S_WALK: begin
                    if (i_status.walk_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_in_stall <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/wbec_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed bad event counter datapath
// Holds the timestamp ring, pointer, fill count and window register, and runs
// the pipelined backward walk that counts in-window entries.
// ----------------------------------------------------------------------------
module wbec_dp
    import wbec_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [WIN_W-1:0] i_cfg_wr_data,
    input  logic [DAY_W-1:0] i_scan_day,
    input  logic [SEC_W-1:0] i_scan_second,
    input  logic             i_scan_is_bad,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic [OUT_W-1:0] o_bad_count,
    output logic [OUT_W-1:0] o_newest_slot_out
);

    localparam int PW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(SLOTS);
    localparam int MW = DAY_W + SEC_W;

    localparam logic signed [AGE_W-1:0] SPD_X = AGE_W'(SECONDS_PER_DAY);

    logic [MW-1:0]    r_mem [SLOTS];

    logic [WIN_W-1:0] r_win;
    logic [DAY_W-1:0] r_day;
    logic [SEC_W-1:0] r_sec;
    logic             r_bad;
    logic [PW-1:0]    r_newest;
    logic [PW-1:0]    r_fill;

    logic [AW-1:0]    r_addr;
    logic [PW-1:0]    r_issued;
    logic [PW-1:0]    r_count;
    logic             r_stop;

    logic [MW-1:0]    r_rd;
    logic             r_s1_v;
    logic             r_s1_ok;

    logic signed [AGE_W-1:0] r_prod;
    logic [SEC_W-1:0]        r_s2_ss;
    logic                    r_s2_v;
    logic                    r_s2_ok;

    logic [OUT_W-1:0] r_out_count;
    logic [OUT_W-1:0] r_out_newest;

    logic [PW-1:0]           n_ptr;
    logic                    w_issue;
    logic signed [DAY_W:0]   w_dd;
    logic signed [AGE_W-1:0] w_dd_x;
    logic signed [AGE_W-1:0] w_age;
    logic                    w_pass;
    logic                    w_eval;

    assign n_ptr   = (r_newest == PW'(SLOTS)) ? PW'(1) : r_newest + PW'(1);
    assign w_issue = i_cmd.walk && !r_stop && (r_issued != PW'(SLOTS));

    assign w_dd   = $signed({1'b0, r_day}) - $signed({1'b0, r_rd[MW-1:SEC_W]});
    assign w_dd_x = AGE_W'(w_dd);
    assign w_age  = r_prod - $signed({{(AGE_W-SEC_W){1'b0}}, r_s2_ss})
                  + $signed({{(AGE_W-SEC_W){1'b0}}, r_sec});
    assign w_pass = w_age <= $signed({{(AGE_W-WIN_W){1'b0}}, r_win});
    assign w_eval = i_cmd.walk && r_s2_v && !r_stop;

    assign o_status.empty     = (r_newest == '0);
    assign o_status.walk_done = r_stop
                              || ((r_issued == PW'(SLOTS)) && !r_s1_v && !r_s2_v);

    assign o_bad_count       = r_out_count;
    assign o_newest_slot_out = r_out_newest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= WINDOW_RESET;
            r_newest <= '0;
            r_fill   <= '0;
            r_issued <= '0;
            r_count  <= '0;
            r_stop   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win <= i_cfg_wr_data;
            end
            if (i_cmd.write && r_bad) begin
                r_newest <= n_ptr;
                if (r_fill != PW'(SLOTS)) begin
                    r_fill <= r_fill + PW'(1);
                end
            end
            if (i_cmd.start) begin
                r_issued <= '0;
                r_count  <= '0;
                r_stop   <= 1'b0;
                r_s1_v   <= 1'b0;
                r_s2_v   <= 1'b0;
            end else if (i_cmd.walk) begin
                r_s1_v <= w_issue;
                r_s2_v <= r_s1_v;
                if (w_issue) begin
                    r_issued <= r_issued + PW'(1);
                end
                if (w_eval) begin
                    if (r_s2_ok && w_pass) begin
                        r_count <= r_count + PW'(1);
                    end else begin
                        r_stop <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day <= i_scan_day;
            r_sec <= i_scan_second;
            r_bad <= i_scan_is_bad;
        end
        if (i_cmd.write && r_bad) begin
            r_mem[AW'(n_ptr - PW'(1))] <= {r_day, r_sec};
        end
        if (i_cmd.start) begin
            r_addr <= AW'(r_newest - PW'(1));
        end else if (w_issue) begin
            r_rd    <= r_mem[r_addr];
            r_s1_ok <= PW'(r_addr) < r_fill;
            r_addr  <= (r_addr == '0) ? AW'(SLOTS - 1) : r_addr - AW'(1);
        end
        if (i_cmd.walk) begin
            r_prod  <= w_dd_x * SPD_X;
            r_s2_ss <= r_rd[SEC_W-1:0];
            r_s2_ok <= r_s1_ok;
        end
        if (i_cmd.publish) begin
            r_out_count  <= OUT_W'(r_count);
            r_out_newest <= OUT_W'(r_newest);
        end
    end

endmodule

// ===== sv/windowed_bad_event_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed bad event counter
// Records bad scans in a timestamp ring and reports, for every scan, how many
// of the newest recorded bad scans fall inside the configured age window.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    scan_day, scan_second, scan_is_bad
//  out      output     o_out_valid / i_out_stall  bad_count, newest_slot_out
//  cfg      input      i_cfg_wr_en                window_seconds
//
//  An item with an empty ring skips the walk; otherwise the walk reads one
//  ring entry per cycle from the single read port of the timestamp memory,
//  behind a three-stage read, multiply and compare pipeline. A new item is
//  taken while the previous result still waits in the output register.
//  Reset is synchronous and needs no clearing pass. A stalled output holds
//  its result and delays only the hand-off.
// ----------------------------------------------------------------------------
module windowed_bad_event_counter
    import wbec_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [WIN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [DAY_W-1:0] i_scan_day,
    input  logic [SEC_W-1:0] i_scan_second,
    input  logic             i_scan_is_bad,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OUT_W-1:0] o_bad_count,
    output logic [OUT_W-1:0] o_newest_slot_out
);

    t_cmd    w_cmd;
    t_status w_status;

    wbec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wbec_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_scan_day        (i_scan_day),
        .i_scan_second     (i_scan_second),
        .i_scan_is_bad     (i_scan_is_bad),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_bad_count       (o_bad_count),
        .o_newest_slot_out (o_newest_slot_out)
    );

endmodule

// ===== sv/wbec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed bad event counter checker
// Port-level checks on handshake ordering and result consistency.
// ----------------------------------------------------------------------------
module wbec_checker
    import wbec_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [OUT_W-1:0] o_bad_count,
    input logic [OUT_W-1:0] o_newest_slot_out
);

    localparam bit SMALL_RING = (SLOTS < (1 << OUT_W));

    // The block is idle and has no result after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present after reset");

    // An accepted item keeps the input side stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the item finished");

    // A result appears only as the end of an item that stalled the input.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

    // An empty ring can report no bad scans.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SMALL_RING && o_out_valid && (o_newest_slot_out == '0) |-> o_bad_count == '0)
        else $error("nonzero count with an empty ring");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bad_count)
            && $stable(o_newest_slot_out))
        else $error("stalled result changed");

endmodule

bind windowed_bad_event_counter wbec_checker #(
    .SLOTS (SLOTS)
) u_wbec_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_bad_count       (o_bad_count),
    .o_newest_slot_out (o_newest_slot_out)
);
